FILE: hw/rtl/dual_pi_current_regulator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual PI current regulator
// Short forms for the clocked checks used at the end of the regulator module.
// ----------------------------------------------------------------------------
`ifndef DUAL_PI_CURRENT_REGULATOR_ASSERT_SVH
`define DUAL_PI_CURRENT_REGULATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPCR_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: regulator check failed");

// The consequent must hold in the cycle after the antecedent.
`define DPCR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: regulator sequencing check failed");

`endif

FILE: hw/rtl/dpcr_pkg.sv
// ----------------------------------------------------------------------------
// Dual PI current regulator package
// Beat types, register indexes, microcode format and the microcode program.
// ----------------------------------------------------------------------------
package dpcr_pkg;

  localparam int DEFAULT_SUM_WIDTH = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PC_W = 4;
  localparam int DUTY_MID = 32768;

  // Program addresses that are jump targets.
  localparam logic [PC_W-1:0] STEP_START = 4'd0;
  localparam logic [PC_W-1:0] STEP_EMIT = 4'd9;

  typedef struct packed {
    logic signed [15:0] current_a;
    logic signed [15:0] current_b;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic        clamped;
  } out_beat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_A  = 3'd0,
    REG_TARGET_B  = 3'd1,
    REG_PROP_GAIN = 3'd2,
    REG_INTEG     = 3'd3,
    REG_BUS       = 3'd4,
    REG_BUS_RECIP = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    OP_ERR,     // error = target - current
    OP_SUM,     // saturating integrator update
    OP_MUL_LO,  // product = integ_gain * low half of sum
    OP_MUL_HI,  // acc = low product, product = integ_gain * high half of sum
    OP_ACC_HI,  // acc += high product shifted, product = prop_gain * error
    OP_ADD_P,   // acc = floor(acc / 2^16) + floor(product / 2^8)
    OP_CLAMP,   // clamp acc to the bus limit
    OP_MUL_D,   // product = command * reciprocal of bus voltage
    OP_DUTY,    // duty from product, saturated
    OP_EMIT     // load the output register
  } op_t;

  typedef enum logic [1:0] {
    JC_NONE,     // fall through to the next step
    JC_PHASE_A,  // jump while the first phase is being worked on
    JC_OUT_HOLD  // stay here while the output register is still full
  } jmp_t;

  typedef struct packed {
    op_t             op;
    jmp_t            jmp;
    logic [PC_W-1:0] target;
  } ucode_t;

  function automatic ucode_t ucode_fetch(input logic [PC_W-1:0] addr);
    ucode_t w;
    case (addr)
      4'd0: w = '{op: OP_ERR, jmp: JC_NONE, target: STEP_START};
      4'd1: w = '{op: OP_SUM, jmp: JC_NONE, target: STEP_START};
      4'd2: w = '{op: OP_MUL_LO, jmp: JC_NONE, target: STEP_START};
      4'd3: w = '{op: OP_MUL_HI, jmp: JC_NONE, target: STEP_START};
      4'd4: w = '{op: OP_ACC_HI, jmp: JC_NONE, target: STEP_START};
      4'd5: w = '{op: OP_ADD_P, jmp: JC_NONE, target: STEP_START};
      4'd6: w = '{op: OP_CLAMP, jmp: JC_NONE, target: STEP_START};
      4'd7: w = '{op: OP_MUL_D, jmp: JC_NONE, target: STEP_START};
      4'd8: w = '{op: OP_DUTY, jmp: JC_PHASE_A, target: STEP_START};
      default: w = '{op: OP_EMIT, jmp: JC_OUT_HOLD, target: STEP_EMIT};
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/dual_pi_current_regulator.sv
// ----------------------------------------------------------------------------
// Dual PI current regulator
// Two-phase stationary-frame PI current loop with clamping and duty mapping.
// ----------------------------------------------------------------------------
// A current sample beat is taken when the block is idle. A ten-step microcode
// program runs the nine datapath steps once per phase on one shared
// multiplier and accumulator, then loads the output register. The next input
// beat can be taken in the cycle the duty beat appears. The time per item
// is set by the length of the program, whose phase loop uses the shared
// multiplier four times per phase. If the previous result is still waiting
// in the output register, the final step holds until it is taken.
// Configuration writes take effect at once and are meant for idle periods.
module dual_pi_current_regulator #(
  parameter int SUM_WIDTH = dpcr_pkg::DEFAULT_SUM_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  dpcr_pkg::in_beat_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output dpcr_pkg::out_beat_t                  out_data,
  input  logic                                 cfg_wr_en,
  input  logic [dpcr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dpcr_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import dpcr_pkg::*;

  localparam int LO_W = SUM_WIDTH / 2;
  localparam int HI_W = SUM_WIDTH - LO_W;
  localparam int MA_W = (LO_W + 1 > 17) ? ((LO_W + 1 > HI_W) ? LO_W + 1 : HI_W)
                                        : ((HI_W > 17) ? HI_W : 17);
  localparam int PROD_W = MA_W + 17;
  localparam int ACC_W = SUM_WIDTH + 17;

  // Configuration registers.
  logic signed [15:0] target_a;
  logic signed [15:0] target_b;
  logic [15:0]        prop_gain;
  logic [15:0]        integ_gain;
  logic [14:0]        bus_voltage;
  logic [15:0]        bus_recip;

  // Sequencer.
  logic            busy, busy_next;
  logic [PC_W-1:0] pc, pc_next;
  logic            phase;
  ucode_t          uc;
  logic            in_fire, out_slot_free, emit_go;

  // Datapath.
  logic signed [15:0]          cur_a, cur_b;
  logic signed [SUM_WIDTH-1:0] sum_a, sum_b;
  logic signed [16:0]          err;
  logic signed [PROD_W-1:0]    prod;
  logic signed [ACC_W-1:0]     acc;
  logic signed [15:0]          vcmd;
  logic                        clip;
  logic [15:0]                 duty_a, duty_b;

  logic signed [15:0]          tgt_sel, cur_sel;
  logic signed [SUM_WIDTH-1:0] sum_sel, sum_sat;
  logic signed [SUM_WIDTH:0]   sum_wide;
  logic signed [16:0]          err_calc;
  logic signed [LO_W:0]        sum_lo_ext;
  logic signed [HI_W-1:0]      sum_hi;
  logic signed [16:0]          integ_ext, prop_ext, recip_ext;
  logic signed [MA_W-1:0]      mul_a;
  logic signed [16:0]          mul_b;
  logic signed [PROD_W-1:0]    mul_p;
  logic signed [ACC_W-1:0]     bus_pos, bus_neg;
  logic signed [15:0]          bus_lim;
  logic signed [15:0]          clamp_v;
  logic                        clamp_hit;
  logic signed [PROD_W-1:0]    duty_full;
  logic [15:0]                 duty_sat;

  assign uc            = ucode_fetch(pc);
  assign in_ready      = !busy;
  assign in_fire       = in_valid && in_ready;
  assign out_slot_free = !out_valid || out_ready;
  assign emit_go       = busy && (uc.op == OP_EMIT) && out_slot_free;

  // Configuration write port.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_a    <= 16'sd256;
      target_b    <= -16'sd256;
      prop_gain   <= 16'd256;
      integ_gain  <= 16'd0;
      bus_voltage <= 15'd6144;
      bus_recip   <= 16'd2731;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TARGET_A:  target_a    <= cfg_data;
        REG_TARGET_B:  target_b    <= cfg_data;
        REG_PROP_GAIN: prop_gain   <= cfg_data;
        REG_INTEG:     integ_gain  <= cfg_data;
        REG_BUS:       bus_voltage <= cfg_data[14:0];
        REG_BUS_RECIP: bus_recip   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Step counter and conditional jumps.
  always_comb begin
    pc_next   = pc;
    busy_next = busy;
    if (!busy) begin
      if (in_fire) begin
        pc_next   = STEP_START;
        busy_next = 1'b1;
      end
    end else begin
      case (uc.jmp)
        JC_NONE:    pc_next = pc + PC_W'(1);
        JC_PHASE_A: pc_next = phase ? pc + PC_W'(1) : uc.target;
        JC_OUT_HOLD: begin
          if (out_slot_free) begin
            busy_next = 1'b0;
          end else begin
            pc_next = uc.target;
          end
        end
        default:    pc_next = pc + PC_W'(1);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= STEP_START;
    end else begin
      busy <= busy_next;
      pc   <= pc_next;
    end
  end

  // Phase selection.
  assign tgt_sel = phase ? target_b : target_a;
  assign cur_sel = phase ? cur_b : cur_a;
  assign sum_sel = phase ? sum_b : sum_a;

  assign err_calc = 17'(tgt_sel) - 17'(cur_sel);

  // The integrator saturates when the sign of the widened sum disagrees.
  assign sum_wide = (SUM_WIDTH + 1)'(sum_sel) + (SUM_WIDTH + 1)'(err);
  always_comb begin
    if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
      sum_sat = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH - 1){1'b0}}}
                                    : {1'b0, {(SUM_WIDTH - 1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_WIDTH-1:0];
    end
  end

  // The integral product is split in two halves to keep the multiplier narrow.
  assign sum_lo_ext = {1'b0, sum_sel[LO_W-1:0]};
  assign sum_hi     = sum_sel[SUM_WIDTH-1:LO_W];
  assign integ_ext  = {1'b0, integ_gain};
  assign prop_ext   = {1'b0, prop_gain};
  assign recip_ext  = {1'b0, bus_recip};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (uc.op)
      OP_MUL_LO: begin
        mul_a = MA_W'(sum_lo_ext);
        mul_b = integ_ext;
      end
      OP_MUL_HI: begin
        mul_a = MA_W'(sum_hi);
        mul_b = integ_ext;
      end
      OP_ACC_HI: begin
        mul_a = MA_W'(err);
        mul_b = prop_ext;
      end
      OP_MUL_D: begin
        mul_a = MA_W'(vcmd);
        mul_b = recip_ext;
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Symmetric clamp against the bus voltage.
  assign bus_lim = {1'b0, bus_voltage};
  assign bus_pos = ACC_W'(bus_lim);
  assign bus_neg = -bus_pos;

  always_comb begin
    clamp_hit = 1'b0;
    clamp_v   = acc[15:0];
    if (acc > bus_pos) begin
      clamp_hit = 1'b1;
      clamp_v   = bus_lim;
    end else if (acc < bus_neg) begin
      clamp_hit = 1'b1;
      clamp_v   = -bus_lim;
    end
  end

  assign duty_full = (prod >>> 9) + PROD_W'(DUTY_MID);
  always_comb begin
    if (duty_full[PROD_W-1]) begin
      duty_sat = '0;
    end else if (|duty_full[PROD_W-2:16]) begin
      duty_sat = '1;
    end else begin
      duty_sat = duty_full[15:0];
    end
  end

  // Integrator state.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_a <= '0;
      sum_b <= '0;
    end else if (busy && uc.op == OP_SUM) begin
      if (phase) begin
        sum_b <= sum_sat;
      end else begin
        sum_a <= sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      clip  <= 1'b0;
    end else if (in_fire) begin
      phase <= 1'b0;
      clip  <= 1'b0;
    end else if (busy) begin
      if (uc.op == OP_DUTY) begin
        phase <= ~phase;
      end
      if (uc.op == OP_CLAMP && clamp_hit) begin
        clip <= 1'b1;
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_a <= in_data.current_a;
      cur_b <= in_data.current_b;
    end
    if (busy) begin
      case (uc.op)
        OP_ERR:    err <= err_calc;
        OP_MUL_LO: prod <= mul_p;
        OP_MUL_HI: begin
          acc  <= ACC_W'(prod);
          prod <= mul_p;
        end
        OP_ACC_HI: begin
          acc  <= acc + (ACC_W'(prod) <<< LO_W);
          prod <= mul_p;
        end
        OP_ADD_P:  acc <= (acc >>> 16) + ACC_W'(prod >>> 8);
        OP_CLAMP:  vcmd <= clamp_v;
        OP_MUL_D:  prod <= mul_p;
        OP_DUTY: begin
          if (phase) begin
            duty_b <= duty_sat;
          end else begin
            duty_a <= duty_sat;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_data <= '{duty_a: duty_a, duty_b: duty_b, clamped: clip};
    end
  end

`include "dual_pi_current_regulator_assert.svh"

  `DPCR_ASSERT_NEXT(a_start, in_fire, busy && pc == STEP_START && !phase && !clip)
  `DPCR_ASSERT_NEXT(a_phase_loop, busy && uc.op == OP_DUTY && !phase, busy && phase && pc == STEP_START)
  `DPCR_ASSERT_NEXT(a_clamp_range, busy && uc.op == OP_CLAMP, (vcmd <= bus_lim) && (vcmd >= -bus_lim))
  `DPCR_ASSERT_NEXT(a_emit, emit_go, out_valid && !busy && out_data.clamped == $past(clip))
  `DPCR_ASSERT_NOW(a_emit_hold, busy && uc.op == OP_EMIT && out_valid && !out_ready, !emit_go && pc_next == pc)

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// Dual PI current regulator testbench
// Drives phase current samples through the regulator under a series of
// register settings and checks every duty beat against a cycle-free model of
// the two PI loops, including the integrator state carried across beats.
// ----------------------------------------------------------------------------
module testbench;
  import dpcr_pkg::*;

  localparam int ACC_W = DEFAULT_SUM_WIDTH;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_SETTINGS = 8;
  localparam int ITEMS_PER_SETTING = 80;
  localparam int IDLE_PCT = 28;
  localparam int CALM_SETTING = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  // Model of both current loops and the queue of duty beats still owed.
  class pi_loop_model #(int SUM_W = 32);
    logic signed [15:0] target_a;
    logic signed [15:0] target_b;
    logic [15:0] kp;
    logic [15:0] ki_ts;
    logic [14:0] vbus;
    logic [15:0] vbus_recip;
    longint integ[2];
    bit clip_hit;
    out_beat_t duty_queue[$];
    int mismatches;
    int samples;
    int checked;
    int clamps;

    function new();
      target_a = 16'sd256;
      target_b = -16'sd256;
      kp = 16'd256;
      ki_ts = 16'd0;
      vbus = 15'd6144;
      vbus_recip = 16'd2731;
      integ[0] = 0;
      integ[1] = 0;
      mismatches = 0;
      samples = 0;
      checked = 0;
      clamps = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TARGET_A: target_a = data;
        REG_TARGET_B: target_b = data;
        REG_PROP_GAIN: kp = data;
        REG_INTEG: ki_ts = data;
        REG_BUS: vbus = data[14:0];
        REG_BUS_RECIP: vbus_recip = data;
        default: ;
      endcase
    endfunction

    function logic [15:0] phase_duty(longint target, longint current, int ch);
      longint err;
      longint v;
      longint d;
      longint hi;
      longint lo;
      longint bus;
      err = target - current;
      hi = (longint'(1) <<< (SUM_W - 1)) - 1;
      lo = -hi - 1;
      integ[ch] = integ[ch] + err;
      if (integ[ch] > hi) integ[ch] = hi;
      if (integ[ch] < lo) integ[ch] = lo;
      // Arithmetic shifts of signed values round toward minus infinity.
      v = ((err * longint'(kp)) >>> 8) + ((integ[ch] * longint'(ki_ts)) >>> 16);
      bus = longint'(vbus);
      if (v > bus) begin
        v = bus;
        clip_hit = 1'b1;
      end else if (v < -bus) begin
        v = -bus;
        clip_hit = 1'b1;
      end
      d = longint'(DUTY_MID) + ((v * longint'(vbus_recip)) >>> 9);
      if (d < 0) d = 0;
      if (d > 65535) d = 65535;
      return d[15:0];
    endfunction

    function void take_sample(in_beat_t s);
      out_beat_t e;
      clip_hit = 1'b0;
      e.duty_a = phase_duty(longint'(target_a), longint'($signed(s.current_a)), 0);
      e.duty_b = phase_duty(longint'(target_b), longint'($signed(s.current_b)), 1);
      e.clamped = clip_hit;
      if (clip_hit) clamps++;
      samples++;
      duty_queue.push_back(e);
    endfunction

    function void check_duties(out_beat_t got);
      out_beat_t e;
      if (duty_queue.size() == 0) begin
        $error("duty beat with none outstanding: duty_a %0d duty_b %0d clamped %0b",
               got.duty_a, got.duty_b, got.clamped);
        mismatches++;
        return;
      end
      e = duty_queue.pop_front();
      checked++;
      if (got.duty_a !== e.duty_a) begin
        $error("duty_a: expected %0d, got %0d", e.duty_a, got.duty_a);
        mismatches++;
      end
      if (got.duty_b !== e.duty_b) begin
        $error("duty_b: expected %0d, got %0d", e.duty_b, got.duty_b);
        mismatches++;
      end
      if (got.clamped !== e.clamped) begin
        $error("clamped: expected %0b, got %0b", e.clamped, got.clamped);
        mismatches++;
      end
    endfunction

    function int waiting();
      return duty_queue.size();
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit calm = 1'b0;
  int settings_run = 0;
  pi_loop_model #(ACC_W) model;

  dual_pi_current_regulator #(.SUM_WIDTH(ACC_W)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Values read right after the edge are the ones the block saw at that edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) model.take_sample(in_data);
      if (out_valid && out_ready) model.check_duties(out_data);
    end
  end

  function automatic int idle_gap();
    int n = 0;
    if (calm) return 0;
    while ($urandom_range(99) < IDLE_PCT) n++;
    return n;
  endfunction

  function automatic in_beat_t beat_of(logic signed [15:0] a, logic signed [15:0] b);
    in_beat_t s;
    s.current_a = a;
    s.current_b = b;
    return s;
  endfunction

  // Mostly samples close to the setpoint so the loops stay out of the clamp.
  function automatic logic signed [15:0] pick_current(logic signed [15:0] target);
    logic signed [15:0] c;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: c = 16'(target + $urandom_range(1023) - 512);
      9: begin
        case ($urandom_range(3))
          0: c = 16'sh7fff;
          1: c = 16'sh8000;
          2: c = 16'sh0000;
          default: c = 16'shffff;
        endcase
      end
      default: c = 16'($urandom);
    endcase
    return c;
  endfunction

  // Each call starts on a clock edge; valid stays high across back-to-back beats.
  task automatic send_sample(input in_beat_t s);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // One edge first, so the monitor has logged the last accepted beat.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (model.waiting() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    model.write_reg(idx, data);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_setting();
    logic [14:0] bus;
    logic [15:0] gain;
    int q;
    write_reg(REG_TARGET_A, 16'($urandom));
    write_reg(REG_TARGET_B, 16'($urandom));
    case ($urandom_range(3))
      0: gain = 16'($urandom_range(255));
      1: gain = 16'($urandom_range(256, 4095));
      2: gain = 16'($urandom);
      default: gain = ($urandom_range(1) == 0) ? 16'h0000 : 16'hffff;
    endcase
    write_reg(REG_PROP_GAIN, gain);
    case ($urandom_range(3))
      0: gain = 16'h0000;
      1: gain = 16'($urandom_range(1, 1023));
      2: gain = 16'($urandom_range(1024, 16383));
      default: gain = 16'($urandom);
    endcase
    write_reg(REG_INTEG, gain);
    if ($urandom_range(7) == 0) bus = 15'($urandom_range(1, 256));
    else bus = 15'($urandom_range(257, 32767));
    // The top data bit lies above the bus register and must be dropped.
    write_reg(REG_BUS, {1'($urandom_range(1)), bus});
    q = (1 << 24) / int'(bus);
    if ($urandom_range(3) == 0) gain = 16'($urandom);
    else gain = (q > 65535) ? 16'hffff : 16'(q);
    write_reg(REG_BUS_RECIP, gain);
    if ($urandom_range(1) == 0)
      write_reg(($urandom_range(1) == 0) ? REG_SPARE_6 : REG_SPARE_7, 16'($urandom));
  endtask

  initial begin
    model = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: unity proportional gain, no integral action.
    settings_run++;
    send_sample(beat_of(16'sh0000, 16'sh0000));
    send_sample(beat_of(16'sh7fff, 16'sh8000));
    send_sample(beat_of(16'sh8000, 16'sh7fff));
    send_sample(beat_of(16'sd256, -16'sd256));
    send_sample(beat_of(-16'sd1, 16'sd1));
    drain();

    // Largest gains, setpoints and bus voltage.
    settings_run++;
    write_reg(REG_TARGET_A, 16'h7fff);
    write_reg(REG_TARGET_B, 16'h8000);
    write_reg(REG_PROP_GAIN, 16'hffff);
    write_reg(REG_INTEG, 16'hffff);
    write_reg(REG_BUS, 16'h7fff);
    write_reg(REG_BUS_RECIP, 16'd2);
    send_sample(beat_of(16'sh8000, 16'sh7fff));
    send_sample(beat_of(16'sh7fff, 16'sh8000));
    send_sample(beat_of(16'sh0000, 16'sh0000));
    send_sample(beat_of(16'sh7fff, 16'sh7fff));
    drain();

    // A bus register of zero reached through a write whose top bit is set.
    settings_run++;
    write_reg(REG_BUS, 16'h8000);
    write_reg(REG_SPARE_6, 16'hffff);
    write_reg(REG_SPARE_7, 16'h1234);
    send_sample(beat_of(16'sh0000, 16'sh0000));
    send_sample(beat_of(16'sd1234, -16'sd1234));
    drain();
    write_reg(REG_PROP_GAIN, 16'h0000);
    write_reg(REG_INTEG, 16'h0000);
    write_reg(REG_BUS_RECIP, 16'h0000);
    send_sample(beat_of(16'sh0000, 16'sh0000));
    send_sample(beat_of(16'sh7fff, 16'sh8000));
    drain();

    // Reciprocal far too large for the bus, so the duty runs into both rails.
    settings_run++;
    write_reg(REG_TARGET_A, 16'h0000);
    write_reg(REG_TARGET_B, 16'h0000);
    write_reg(REG_PROP_GAIN, 16'd256);
    write_reg(REG_BUS, 16'd1000);
    write_reg(REG_BUS_RECIP, 16'hffff);
    send_sample(beat_of(-16'sd1000, 16'sd1000));
    send_sample(beat_of(-16'sd1001, 16'sd1001));
    send_sample(beat_of(16'sh0000, 16'sh0000));

    for (int k = 0; k < RANDOM_SETTINGS; k++) begin
      drain();
      random_setting();
      settings_run++;
      calm = (k == CALM_SETTING);
      for (int n = 0; n < ITEMS_PER_SETTING; n++)
        send_sample(beat_of(pick_current(model.target_a), pick_current(model.target_b)));
    end
    calm = 1'b0;
    drain();

    $display("Ran %0d current samples under %0d register settings, zero bus included.",
             model.samples, settings_run);
    $display("Checked %0d duty beats, %0d of them with a clamped command.",
             model.checked, model.clamps);
    if (model.mismatches == 0 && model.waiting() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/dpcr_pkg.sv
hw/rtl/dual_pi_current_regulator.sv
bench/testbench.sv
